// ===== rtl/ptq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer queue package
// Shared beat types, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptq_pkg;

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_REGISTER = 2'd1;
   localparam logic [1:0] OP_REMOVE   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // At most this many fired ids are reported for one tick.
   localparam int RESULT_CAP = 16;
   localparam int CNT_W      = 5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] first_delay;
      logic [15:0] reload_period;
      logic [3:0]  timer_id;
   } req_type;

   typedef struct packed {
      logic [3:0] result_id;
      logic [1:0] status;
      logic       fired;
      logic       last_result;
   } rsp_type;

   typedef struct packed {
      logic tick_start;
      logic scan_step;
      logic drain;
      logic op_register;
      logic op_remove;
      logic op_other;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic need_emit;
      logic scan_last;
   } sts_type;

endpackage

// ===== rtl/periodic_task_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task timer queue
// A table of NUM_TIMERS periodic timers with register, remove and tick
// requests and a stream of result beats.
// ----------------------------------------------------------------------------
// A register request takes the lowest free slot and answers with its id, or
// reports a full table; a remove request frees a slot or reports that the id
// was not found; each gives one result beat. A tick sweeps every slot in
// ascending order, one slot per cycle while no fired id waits for the result
// register, through the read port of the count and period memories: a live
// timer at zero fires and reloads to its period, any other live timer counts
// down. The fired ids leave in slot order as one beat each, the final one
// marked last (at most sixteen are reported, ids modulo sixteen); a tick
// where nothing fired gives one beat with fired low. A tick holds the block
// from its acceptance through one step per slot and a closing step for the
// final beat, and longer while the result port stalls a beat. A timer
// fires after first_delay + 1 ticks and then every reload_period + 1 ticks.
// Requests are taken one at a time; a new request is taken while the previous
// result beat still waits in the output register only once that beat is
// being taken. Reset clears all slots at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_task_timer_queue #(
   parameter int NUM_TIMERS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptq_pkg::rsp_type rsp_data
);

   // Commands from the controller and status back from the datapath.
   ptq_pkg::cmd_type cmd;
   ptq_pkg::sts_type sts;

   ptq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_data.operation),
      .sts      (sts),
      .cmd      (cmd),
      .req_stall(req_stall)
   );

   ptq_dpath #(.NUM_TIMERS(NUM_TIMERS)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req      (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // A request is never taken while an unsent result would be overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!rsp_valid || !rsp_stall))
      else $error("request accepted while result beat is blocked");

   // Only a fired id may leave without the last mark.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_result) |-> rsp_data.fired)
      else $error("non-final beat without a fired id");

   // No request is taken during the tick sweep.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !(req_valid && !req_stall))
      else $error("request accepted during tick sweep");

   // Closing a tick always presents a final beat.
   assert property (@(posedge clock) disable iff (reset)
      cmd.drain |=> (rsp_valid && rsp_data.last_result))
      else $error("tick closed without final beat");

endmodule

// ===== rtl/ptq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ptq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ptq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer queue controller
// Accepts requests, steps the tick sweep and closes each tick with its last
// beat.
// ----------------------------------------------------------------------------
module ptq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_op,
   input  ptq_pkg::sts_type sts,
   output ptq_pkg::cmd_type cmd,
   output logic             req_stall
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      step;

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      state_in  = state_ff;
      step      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = !sts.out_free;
            if (req_valid && sts.out_free) begin
               unique case (req_op)
                  ptq_pkg::OP_TICK: begin
                     cmd.tick_start = 1'b1;
                     state_in       = S_SCAN;
                  end
                  ptq_pkg::OP_REGISTER: cmd.op_register = 1'b1;
                  ptq_pkg::OP_REMOVE:   cmd.op_remove   = 1'b1;
                  default:              cmd.op_other    = 1'b1;
               endcase
            end
         end
         S_SCAN: begin
            // A slot that must push out the previous fired id waits for room.
            step          = !sts.need_emit || sts.out_free;
            cmd.scan_step = step;
            if (step && sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (sts.out_free) begin
               cmd.drain = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/ptq_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer queue datapath
// Slot valid bits, count and period memories, the tick sweep registers and
// the result register.
// ----------------------------------------------------------------------------
module ptq_dpath #(
   parameter int NUM_TIMERS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  ptq_pkg::req_type req,
   input  ptq_pkg::cmd_type cmd,
   output ptq_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptq_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(NUM_TIMERS);

   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [3:0]            pend_id_ff, pend_id_in;
   logic [ptq_pkg::CNT_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ptq_pkg::rsp_type      rsp_ff, rsp_in;

   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic [IDX_W-1:0] id_idx;
   logic             id_ok;
   logic             cur_valid, fire, report, scan_last, out_free;

   logic             rem_wr_en, per_wr_en, rd_en;
   logic [IDX_W-1:0] rem_wr_addr, rd_addr;
   logic [15:0]      rem_wr_data, rem_rd, per_rd;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign id_idx = IDX_W'(req.timer_id);
   assign id_ok  = ({28'd0, req.timer_id} < 32'(NUM_TIMERS)) && valid_ff[id_idx];

   assign cur_valid = valid_ff[scan_idx_ff];
   assign fire      = cur_valid && (rem_rd == 16'd0);
   assign report    = fire && (fire_cnt_ff < ptq_pkg::CNT_W'(ptq_pkg::RESULT_CAP));
   assign scan_last = (scan_idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign sts.out_free  = out_free;
   assign sts.need_emit = report && pend_valid_ff;
   assign sts.scan_last = scan_last;

   // Memory ports. The sweep writes back slot i while reading slot i+1.
   assign rem_wr_en   = (cmd.op_register && free_found) || (cmd.scan_step && cur_valid);
   assign rem_wr_addr = cmd.op_register ? free_idx : scan_idx_ff;
   assign rem_wr_data = cmd.op_register ? req.first_delay
                      : (fire ? per_rd : rem_rd - 16'd1);
   assign per_wr_en   = cmd.op_register && free_found;
   assign rd_en       = cmd.tick_start || (cmd.scan_step && !scan_last);
   assign rd_addr     = cmd.tick_start ? '0 : scan_idx_ff + IDX_W'(1);

   ptq_ram #(.WIDTH(16), .DEPTH(NUM_TIMERS)) u_remaining (
      .clock  (clock),
      .wr_en  (rem_wr_en),
      .wr_addr(rem_wr_addr),
      .wr_data(rem_wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rem_rd)
   );

   ptq_ram #(.WIDTH(16), .DEPTH(NUM_TIMERS)) u_period (
      .clock  (clock),
      .wr_en  (per_wr_en),
      .wr_addr(free_idx),
      .wr_data(req.reload_period),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(per_rd)
   );

   always_comb begin
      valid_in      = valid_ff;
      scan_idx_in   = scan_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      fire_cnt_in   = fire_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;

      if (cmd.op_register) begin
         if (free_found) begin
            valid_in[free_idx] = 1'b1;
         end
         rsp_in.result_id   = free_found ? 4'(free_idx) : 4'd0;
         rsp_in.status      = free_found ? ptq_pkg::ST_OK : ptq_pkg::ST_FULL;
         rsp_in.fired       = 1'b0;
         rsp_in.last_result = 1'b1;
         rsp_valid_in       = 1'b1;
      end

      if (cmd.op_remove) begin
         if (id_ok) begin
            valid_in[id_idx] = 1'b0;
         end
         rsp_in.result_id   = req.timer_id;
         rsp_in.status      = id_ok ? ptq_pkg::ST_OK : ptq_pkg::ST_NOT_FOUND;
         rsp_in.fired       = 1'b0;
         rsp_in.last_result = 1'b1;
         rsp_valid_in       = 1'b1;
      end

      if (cmd.op_other) begin
         rsp_in       = '0;
         rsp_in.last_result = 1'b1;
         rsp_valid_in = 1'b1;
      end

      if (cmd.tick_start) begin
         scan_idx_in   = '0;
         pend_valid_in = 1'b0;
         fire_cnt_in   = '0;
      end

      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
         if (report) begin
            // The held id is known not to be the last one, so send it now.
            if (pend_valid_ff) begin
               rsp_in.result_id   = pend_id_ff;
               rsp_in.status      = ptq_pkg::ST_OK;
               rsp_in.fired       = 1'b1;
               rsp_in.last_result = 1'b0;
               rsp_valid_in       = 1'b1;
            end
            pend_valid_in = 1'b1;
            pend_id_in    = 4'(scan_idx_ff);
            fire_cnt_in   = fire_cnt_ff + ptq_pkg::CNT_W'(1);
         end
      end

      if (cmd.drain) begin
         rsp_in.result_id   = pend_valid_ff ? pend_id_ff : 4'd0;
         rsp_in.status      = ptq_pkg::ST_OK;
         rsp_in.fired       = pend_valid_ff;
         rsp_in.last_result = 1'b1;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_idx_ff <= scan_idx_in;
      pend_id_ff  <= pend_id_in;
      fire_cnt_ff <= fire_cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
